// ----- rtl/hic_pkg.sv -----
// Shared types and constants of the homography inlier counter.
`default_nettype none
package hic_pkg;

    // Fixed datapath widths (sized for the widest coordinate fraction setting)
    localparam int COEF_W   = 32;
    localparam int COORD_W  = 16;
    localparam int PROD_W   = COEF_W + COORD_W;
    localparam int SUM_W    = 50;
    localparam int NUM_W    = SUM_W + 8;
    localparam int STEP_W   = $clog2(NUM_W);
    localparam int MAG_W    = 25;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int THR_W    = 32;
    localparam int THR_FRAC = 8;
    localparam int TOTAL_W  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_PAIR_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_PAIR_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_PAIR_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_PAIR_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_H22    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd5;

    typedef struct packed {
        logic signed [COEF_W-1:0] h00;
        logic signed [COEF_W-1:0] h01;
        logic signed [COEF_W-1:0] h02;
        logic signed [COEF_W-1:0] h10;
        logic signed [COEF_W-1:0] h11;
        logic signed [COEF_W-1:0] h12;
        logic signed [COEF_W-1:0] h20;
        logic signed [COEF_W-1:0] h21;
        logic signed [COEF_W-1:0] h22;
    } hic_coef_t;

    // Projected sums handed from the front to the back
    typedef struct packed {
        logic signed [SUM_W-1:0]   nx;
        logic signed [SUM_W-1:0]   ny;
        logic signed [SUM_W-1:0]   z;
        logic signed [COORD_W-1:0] tx;
        logic signed [COORD_W-1:0] ty;
        logic                      last;
    } hic_work_t;

    typedef struct packed {
        logic      push;
        hic_work_t push_data;
        logic      pop;
    } hic_qctl_t;

    typedef struct packed {
        logic      full;
        logic      empty;
        hic_work_t pop_data;
    } hic_qsts_t;

endpackage
`default_nettype wire

// ----- rtl/hic_if.sv -----
// Item channels of the homography inlier counter.
`default_nettype none
interface hic_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] src_x;
    logic signed [15:0] src_y;
    logic signed [15:0] dst_x;
    logic signed [15:0] dst_y;
    logic               last_pair;

    modport source (output valid, src_x, src_y, dst_x, dst_y, last_pair, input ready);
    modport sink (input valid, src_x, src_y, dst_x, dst_y, last_pair, output ready);
endinterface

interface hic_out_if;
    logic        valid;
    logic        ready;
    logic        is_inlier;
    logic        zero_denominator;
    logic [15:0] inlier_total;
    logic        set_done;

    modport source (output valid, is_inlier, zero_denominator, inlier_total, set_done,
                    input ready);
    modport sink (input valid, is_inlier, zero_denominator, inlier_total, set_done,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/homography_inlier_counter.sv -----
// Homography inlier counter: projects point pairs and counts inliers per set.
//
// Usage: pair_in carries one correspondence per item (source and target
// points in signed fixed point, last_pair closing a set). result_out carries
// one item per pair: is_inlier, zero_denominator, the running inlier_total
// of the set including this pair, and set_done copied from last_pair.
// Both channels use valid/ready; an item moves when both are high.
// Registers are to be written by the user through cfg_we/cfg_index/cfg_data
// only while idle; the block itself does not enforce this. An accepted pair
// passes two front stages, one queue write, one load, 58 divide steps, then
// the offset, square and compare states before its result is valid. The
// bit-serial perspective divider handles one pair at a time.
// The front pipeline and a two-entry queue keep accepting pairs while the
// divider works, until the queue fills.
// Reset clears the tally, the queue and all valid flags, and loads the
// identity homography with a threshold of 2304.
// A stalled receiver holds the result register; the back end finishes the
// next pair and waits, then the queue and front fill and pair_in.ready drops.
`default_nettype none
module homography_inlier_counter #(
    parameter int COORD_FRAC_BITS = 4,
    parameter int COEF_FRAC_BITS  = 16,
    parameter int COUNT_WIDTH     = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    hic_in_if.sink                                 pair_in,
    hic_out_if.source                              result_out,
    input  wire logic                              cfg_we,
    input  wire logic [hic_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [hic_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import hic_pkg::*;

    logic [63:0] pair0_reg, pair1_reg, pair2_reg, pair3_reg;
    logic [31:0] h22_reg;
    logic [31:0] thr_reg;
    hic_coef_t   coef;
    hic_qctl_t   qctl;
    hic_qsts_t   qsts;
    logic        push;
    hic_work_t   push_data;
    logic        pop;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair0_reg <= 64'(1) << (32 + COEF_FRAC_BITS);
            pair1_reg <= '0;
            pair2_reg <= 64'(1) << (32 + COEF_FRAC_BITS);
            pair3_reg <= '0;
            h22_reg   <= 32'(1) << COEF_FRAC_BITS;
            thr_reg   <= 32'd2304;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COEF_PAIR_0: pair0_reg <= cfg_data;
                CFG_COEF_PAIR_1: pair1_reg <= cfg_data;
                CFG_COEF_PAIR_2: pair2_reg <= cfg_data;
                CFG_COEF_PAIR_3: pair3_reg <= cfg_data;
                CFG_COEF_H22:    h22_reg   <= cfg_data[31:0];
                CFG_THRESHOLD:   thr_reg   <= cfg_data[31:0];
                default:         ;
            endcase
        end
    end

    // Unpack coefficients and gather the queue controls
    always_comb
    begin
        coef.h00 = pair0_reg[63:32];
        coef.h01 = pair0_reg[31:0];
        coef.h02 = pair1_reg[63:32];
        coef.h10 = pair1_reg[31:0];
        coef.h11 = pair2_reg[63:32];
        coef.h12 = pair2_reg[31:0];
        coef.h20 = pair3_reg[63:32];
        coef.h21 = pair3_reg[31:0];
        coef.h22 = h22_reg;
        qctl.push      = push;
        qctl.push_data = push_data;
        qctl.pop       = pop;
    end

    hic_front #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pair_in   (pair_in),
        .coef      (coef),
        .qsts      (qsts),
        .push      (push),
        .push_data (push_data)
    );

    hic_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .qctl  (qctl),
        .qsts  (qsts)
    );

    hic_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qsts         (qsts),
        .threshold_sq (thr_reg),
        .pop          (pop),
        .result_out   (result_out)
    );

endmodule
`default_nettype wire

// ----- rtl/hic_front.sv -----
// Front pipeline: multiplies and sums the homography rows for each item.
`default_nettype none
module hic_front #(
    parameter int COORD_FRAC_BITS = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    hic_in_if.sink                 pair_in,
    input  wire hic_pkg::hic_coef_t coef,
    input  wire hic_pkg::hic_qsts_t qsts,
    output logic                   push,
    output hic_pkg::hic_work_t     push_data
);
    import hic_pkg::*;

    logic                      s1_v_reg;
    logic                      s2_v_reg;
    logic                      stall;
    logic signed [PROD_W-1:0]  p00_reg, p01_reg, p10_reg, p11_reg, p20_reg, p21_reg;
    logic signed [COORD_W-1:0] tx1_reg, ty1_reg;
    logic                      last1_reg;
    hic_work_t                 work_reg;

    // Hold the whole pipeline while stage two holds an item and the queue is full
    assign stall         = s2_v_reg && qsts.full;
    assign pair_in.ready = !stall;
    assign push          = s2_v_reg && !qsts.full;
    assign push_data     = work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else if (!stall)
        begin
            s1_v_reg <= pair_in.valid;
            s2_v_reg <= s1_v_reg;
        end
    end

    // Stage one: products of the coefficients with the source point
    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            p00_reg   <= coef.h00 * pair_in.src_x;
            p01_reg   <= coef.h01 * pair_in.src_y;
            p10_reg   <= coef.h10 * pair_in.src_x;
            p11_reg   <= coef.h11 * pair_in.src_y;
            p20_reg   <= coef.h20 * pair_in.src_x;
            p21_reg   <= coef.h21 * pair_in.src_y;
            tx1_reg   <= pair_in.dst_x;
            ty1_reg   <= pair_in.dst_y;
            last1_reg <= pair_in.last_pair;
        end
    end

    // Stage two: row sums with the translation terms shifted to the coordinate fraction
    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            work_reg.nx   <= SUM_W'(p00_reg) + SUM_W'(p01_reg)
                             + (SUM_W'(coef.h02) <<< COORD_FRAC_BITS);
            work_reg.ny   <= SUM_W'(p10_reg) + SUM_W'(p11_reg)
                             + (SUM_W'(coef.h12) <<< COORD_FRAC_BITS);
            work_reg.z    <= SUM_W'(p20_reg) + SUM_W'(p21_reg)
                             + (SUM_W'(coef.h22) <<< COORD_FRAC_BITS);
            work_reg.tx   <= tx1_reg;
            work_reg.ty   <= ty1_reg;
            work_reg.last <= last1_reg;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/hic_queue.sv -----
// Two-entry queue between the front pipeline and the divide back end.
`default_nettype none
module hic_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hic_pkg::hic_qctl_t qctl,
    output hic_pkg::hic_qsts_t     qsts
);
    import hic_pkg::*;

    hic_work_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign qsts.full     = (count_reg == 2'd2);
    assign qsts.empty    = (count_reg == 2'd0);
    assign qsts.pop_data = mem_reg[rd_ptr_reg];
    assign do_push       = qctl.push && !qsts.full;
    assign do_pop        = qctl.pop && !qsts.empty;

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                count_reg <= count_reg + 2'd1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= qctl.push_data;
    end

endmodule
`default_nettype wire

// ----- rtl/hic_back.sv -----
// Back end: perspective divide, distance test and inlier tally.
`default_nettype none
module hic_back #(
    parameter int COORD_FRAC_BITS = 4,
    parameter int COUNT_WIDTH     = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hic_pkg::hic_qsts_t qsts,
    input  wire logic [31:0]        threshold_sq,
    output logic                    pop,
    hic_out_if.source               result_out
);
    import hic_pkg::*;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_DIV  = 5'b00010,
        B_DIFF = 5'b00100,
        B_SQR  = 5'b01000,
        B_EMIT = 5'b10000
    } hic_bstate_t;

    hic_bstate_t              state_reg;
    logic [STEP_W-1:0]        step_reg;
    logic [SUM_W:0]           rem_x_reg, rem_y_reg;
    logic [NUM_W-1:0]         q_x_reg, q_y_reg;
    logic [SUM_W-1:0]         dvs_reg;
    logic                     neg_x_reg, neg_y_reg;
    logic signed [COORD_W-1:0] tx_reg, ty_reg;
    logic                     last_reg;
    logic                     zden_reg;
    logic [MAG_W-1:0]         adx_reg, ady_reg;
    logic                     far_reg;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;
    logic [COUNT_WIDTH-1:0]   tally_reg;
    logic [COUNT_WIDTH-1:0]   tally_next;
    logic                     out_v_reg;
    logic                     inl_reg, zd_out_reg, done_reg;
    logic [TOTAL_W-1:0]       total_reg;

    logic signed [NUM_W-1:0]  num_x, num_y;
    logic [NUM_W-1:0]         mag_x, mag_y;
    logic [SUM_W-1:0]         mag_z;
    logic [SUM_W:0]           trial_x, trial_y;
    logic                     ge_x, ge_y;
    logic signed [NUM_W+1:0]  dx, dy;
    logic [NUM_W+1:0]         adx, ady;
    logic [SQ_W:0]            d2;
    logic [SQ_W+THR_FRAC:0]   lhs, rhs;
    logic                     inl;
    logic                     emit;
    logic [31:0]              tally_wide;

    // Signed numerators and magnitudes at load
    always_comb
    begin
        num_x = NUM_W'(qsts.pop_data.nx) <<< COORD_FRAC_BITS;
        num_y = NUM_W'(qsts.pop_data.ny) <<< COORD_FRAC_BITS;
        mag_x = num_x[NUM_W-1] ? NUM_W'(-num_x) : NUM_W'(num_x);
        mag_y = num_y[NUM_W-1] ? NUM_W'(-num_y) : NUM_W'(num_y);
        mag_z = qsts.pop_data.z[SUM_W-1] ? SUM_W'(-qsts.pop_data.z)
                                         : SUM_W'(qsts.pop_data.z);
    end

    // One restoring divide step per cycle for both coordinates
    always_comb
    begin
        trial_x = {rem_x_reg[SUM_W-1:0], q_x_reg[NUM_W-1]};
        trial_y = {rem_y_reg[SUM_W-1:0], q_y_reg[NUM_W-1]};
        ge_x    = trial_x >= {1'b0, dvs_reg};
        ge_y    = trial_y >= {1'b0, dvs_reg};
    end

    // Signed offsets from the target and their magnitudes
    always_comb
    begin
        dx  = (neg_x_reg ? -$signed({2'b00, q_x_reg}) : $signed({2'b00, q_x_reg}))
              - (NUM_W+2)'(tx_reg);
        dy  = (neg_y_reg ? -$signed({2'b00, q_y_reg}) : $signed({2'b00, q_y_reg}))
              - (NUM_W+2)'(ty_reg);
        adx = dx[NUM_W+1] ? (NUM_W+2)'(-dx) : (NUM_W+2)'(dx);
        ady = dy[NUM_W+1] ? (NUM_W+2)'(-dy) : (NUM_W+2)'(dy);
    end

    // Threshold compare and saturating tally
    always_comb
    begin
        d2   = (SQ_W+1)'(sqx_reg) + (SQ_W+1)'(sqy_reg);
        lhs  = {d2, {THR_FRAC{1'b0}}};
        rhs  = (SQ_W+THR_FRAC+1)'(threshold_sq) << (2 * COORD_FRAC_BITS);
        inl  = !zden_reg && !far_reg && (lhs < rhs);
        emit = (state_reg == B_EMIT) && (!out_v_reg || result_out.ready);
        if (inl && (tally_reg != {COUNT_WIDTH{1'b1}}))
            tally_next = tally_reg + COUNT_WIDTH'(1);
        else
            tally_next = tally_reg;
        tally_wide = 32'(tally_next);
    end

    assign pop = (state_reg == B_IDLE) && !qsts.empty;

    assign result_out.valid            = out_v_reg;
    assign result_out.is_inlier        = inl_reg;
    assign result_out.zero_denominator = zd_out_reg;
    assign result_out.inlier_total     = total_reg;
    assign result_out.set_done         = done_reg;

    // Sequence one item: load, divide, offset, square, emit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg  <= '0;
            tally_reg <= '0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            // Raise valid on a new item, drop it once the item is taken
            if (emit)
                out_v_reg <= 1'b1;
            else if (result_out.ready)
                out_v_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!qsts.empty)
                    begin
                        step_reg  <= '0;
                        state_reg <= B_DIV;
                    end
                end
                B_DIV:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(NUM_W - 1))
                        state_reg <= B_DIFF;
                end
                B_DIFF:
                    state_reg <= B_SQR;
                B_SQR:
                    state_reg <= B_EMIT;
                B_EMIT:
                begin
                    if (emit)
                    begin
                        tally_reg <= last_reg ? '0 : tally_next;
                        state_reg <= B_IDLE;
                    end
                end
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            q_x_reg   <= mag_x;
            q_y_reg   <= mag_y;
            rem_x_reg <= '0;
            rem_y_reg <= '0;
            dvs_reg   <= mag_z;
            neg_x_reg <= num_x[NUM_W-1] ^ qsts.pop_data.z[SUM_W-1];
            neg_y_reg <= num_y[NUM_W-1] ^ qsts.pop_data.z[SUM_W-1];
            zden_reg  <= (qsts.pop_data.z == '0);
            tx_reg    <= qsts.pop_data.tx;
            ty_reg    <= qsts.pop_data.ty;
            last_reg  <= qsts.pop_data.last;
        end
        if (state_reg == B_DIV)
        begin
            rem_x_reg <= ge_x ? trial_x - {1'b0, dvs_reg} : trial_x;
            rem_y_reg <= ge_y ? trial_y - {1'b0, dvs_reg} : trial_y;
            q_x_reg   <= {q_x_reg[NUM_W-2:0], ge_x};
            q_y_reg   <= {q_y_reg[NUM_W-2:0], ge_y};
        end
        if (state_reg == B_DIFF)
        begin
            adx_reg <= adx[MAG_W-1:0];
            ady_reg <= ady[MAG_W-1:0];
            far_reg <= (adx > (NUM_W+2)'(1 << 24)) || (ady > (NUM_W+2)'(1 << 24));
        end
        if (state_reg == B_SQR)
        begin
            sqx_reg <= adx_reg * adx_reg;
            sqy_reg <= ady_reg * ady_reg;
        end
        if (emit)
        begin
            inl_reg    <= inl;
            zd_out_reg <= zden_reg;
            total_reg  <= tally_wide[TOTAL_W-1:0];
            done_reg   <= last_reg;
        end
    end

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for the homography inlier counter: directed table plus predictor-checked random sets.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import hic_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 80;
    localparam int LONG_HOLD   = 3000;

    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        bit                 last;
    } pair_t;

    typedef struct {
        bit          inl;
        bit          zden;
        logic [15:0] total;
        bit          done;
    } verdict_t;

    // One directed row: zero_cfg selects the degenerate homography, known marks a typed result
    typedef struct {
        bit                 zero_cfg;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        bit                 last;
        bit                 known;
        bit                 inl;
        bit                 zden;
        logic [15:0]        total;
    } row_t;

    localparam int NROWS = 12;
    row_t rows [NROWS] = '{
        '{0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd1},
        '{0, 16'sd32, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, 1'b1, 1'b0, 16'd2},
        // exactly on the threshold: strict compare rejects it
        '{0, 16'sd48, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, 1'b0, 1'b0, 16'd2},
        '{0, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 1'b1, 1'b1, 1'b0, 1'b0, 16'd2},
        '{0, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b1, 1'b1, 1'b1, 1'b0, 16'd1},
        '{0, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0, 1'b1, 1'b1, 1'b0, 16'd1},
        '{0, 16'sd100, -16'sd100, 16'sd140, -16'sd100, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0},
        '{0, -16'sd5, 16'sd7, -16'sd5, 16'sd40, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0},
        // zero denominator: never an inlier, tally holds
        '{1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0, 1'b1, 1'b0, 1'b1, 16'd0},
        '{1, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0, 1'b1, 1'b1, 1'b0, 1'b1, 16'd0},
        '{1, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0, 1'b1, 1'b0, 1'b1, 16'd0},
        '{1, 16'sd5, 16'sd5, 16'sd5, 16'sd5, 1'b1, 1'b1, 1'b0, 1'b1, 16'd0}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    hic_in_if  pair_ch ();
    hic_out_if result_ch ();

    homography_inlier_counter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pair_in    (pair_ch),
        .result_out (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Mirror of the configuration and the running tally
    logic [63:0] coef_pairs [4];
    logic [31:0] coef_h22;
    logic [31:0] thr_sq;
    logic [15:0] tally;

    verdict_t pending_verdicts [$];
    int errors;
    int n_pairs, n_inliers, n_zden, n_sets, n_results;
    int burst_left;
    bit long_hold;
    int cycles;

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycles, pending_verdicts.size());
                $display("** homography_inlier_counter: FAILED **");
                $finish;
            end
        end
    end

    // Project a source point; zero set when the perspective divisor vanishes
    task automatic project_point(input logic signed [15:0] sx, input logic signed [15:0] sy,
                                 output longint px, output longint py, output bit zero);
        longint x, y, nx, ny, z;
        x = sx;
        y = sy;
        nx = longint'($signed(coef_pairs[0][63:32])) * x
           + longint'($signed(coef_pairs[0][31:0])) * y
           + longint'($signed(coef_pairs[1][63:32])) * 16;
        ny = longint'($signed(coef_pairs[1][31:0])) * x
           + longint'($signed(coef_pairs[2][63:32])) * y
           + longint'($signed(coef_pairs[2][31:0])) * 16;
        z  = longint'($signed(coef_pairs[3][63:32])) * x
           + longint'($signed(coef_pairs[3][31:0])) * y
           + longint'($signed(coef_h22)) * 16;
        zero = (z == 0);
        px = 0;
        py = 0;
        if (!zero)
        begin
            px = (nx * 16) / z;
            py = (ny * 16) / z;
        end
    endtask

    // Judge one pair against the threshold and advance the set tally
    task automatic judge_pair(input pair_t p, output verdict_t v);
        longint px, py, adx, ady, lhs, rhs;
        bit zero;
        project_point(p.sx, p.sy, px, py, zero);
        v.inl = 1'b0;
        v.zden = zero;
        if (!zero)
        begin
            adx = px - longint'(p.tx);
            ady = py - longint'(p.ty);
            if (adx < 0) adx = -adx;
            if (ady < 0) ady = -ady;
            if (adx <= (64'sd1 << 24) && ady <= (64'sd1 << 24))
            begin
                lhs = (adx * adx + ady * ady) << THR_FRAC;
                rhs = longint'({32'd0, thr_sq}) << 8;
                v.inl = (lhs < rhs);
            end
        end
        if (v.inl && tally != 16'hFFFF)
            tally++;
        v.total = tally;
        v.done = p.last;
        if (p.last)
            tally = '0;
    endtask

    // Write one register, then drop the enable and update the mirror
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_COEF_PAIR_0: coef_pairs[0] = data;
            CFG_COEF_PAIR_1: coef_pairs[1] = data;
            CFG_COEF_PAIR_2: coef_pairs[2] = data;
            CFG_COEF_PAIR_3: coef_pairs[3] = data;
            CFG_COEF_H22:    coef_h22 = data[31:0];
            CFG_THRESHOLD:   thr_sq = data[31:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [63:0] p0, input logic [63:0] p1,
                             input logic [63:0] p2, input logic [63:0] p3,
                             input logic [31:0] h22, input logic [31:0] thr);
        write_reg(CFG_COEF_PAIR_0, p0);
        write_reg(CFG_COEF_PAIR_1, p1);
        write_reg(CFG_COEF_PAIR_2, p2);
        write_reg(CFG_COEF_PAIR_3, p3);
        write_reg(CFG_COEF_H22, {32'd0, h22});
        write_reg(CFG_THRESHOLD, {32'd0, thr});
    endtask

    // Drop valid and wait until every result is back and the pipe has settled
    task automatic drain();
        pair_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Offer one pair in bursts with random gaps; hold until accepted
    task automatic send_pair(input pair_t p, input bit known, input verdict_t typed);
        verdict_t v;
        int gap;
        logic acc;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                pair_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        judge_pair(p, v);
        if (known)
            v = typed;
        pending_verdicts.insert(pending_verdicts.size(), v);
        pair_ch.valid <= 1'b1;
        pair_ch.src_x <= p.sx;
        pair_ch.src_y <= p.sy;
        pair_ch.dst_x <= p.tx;
        pair_ch.dst_y <= p.ty;
        pair_ch.last_pair <= p.last;
        do
        begin
            @(negedge clk);
            acc = pair_ch.ready;
            @(posedge clk);
        end
        while (!acc);
        n_pairs++;
    endtask

    function automatic logic [31:0] near(input int center, input int spread);
        return 32'(center + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // Build a pair; most targets land near the projection so inliers are common
    task automatic make_pair(input int set_len, input bit wide, output pair_t p);
        longint px, py;
        bit zero;
        int r;
        if (wide || $urandom_range(0, 9) == 0)
        begin
            p.sx = 16'($urandom);
            p.sy = 16'($urandom);
        end
        else
        begin
            p.sx = 16'(int'($urandom_range(0, 8000)) - 4000);
            p.sy = 16'(int'($urandom_range(0, 8000)) - 4000);
        end
        p.tx = 16'($urandom);
        p.ty = 16'($urandom);
        project_point(p.sx, p.sy, px, py, zero);
        r = $urandom_range(0, 9);
        if (!zero && r < 7 && px > -32700 && px < 32700 && py > -32700 && py < 32700)
        begin
            p.tx = 16'(px + int'($urandom_range(0, 2 * (r + 1) * 8)) - (r + 1) * 8);
            p.ty = 16'(py + int'($urandom_range(0, 2 * (r + 1) * 8)) - (r + 1) * 8);
        end
        p.last = ($urandom_range(1, set_len) == 1);
    endtask

    task automatic run_random(input int count, input int set_len, input bit wide);
        pair_t p;
        verdict_t none;
        none = '{0, 0, 16'd0, 0};
        for (int i = 0; i < count; i++)
        begin
            make_pair(set_len, wide, p);
            if (i == count - 1)
                p.last = 1'b1;
            send_pair(p, 1'b0, none);
        end
    endtask

    // Receiver: changing stall patterns, plus a long hold on request
    initial
    begin
        int mode;
        int left;
        result_ch.ready <= 1'b0;
        mode = 0;
        left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(50, 400);
            end
            left--;
            case (mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= ($urandom_range(0, 1) == 1);
                default: result_ch.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Compare each delivered item with the oldest expectation
    initial
    begin
        verdict_t e;
        forever
        begin
            @(negedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                n_results++;
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result item inl=%b zden=%b total=%0d done=%b",
                             $realtime, result_ch.is_inlier, result_ch.zero_denominator,
                             result_ch.inlier_total, result_ch.set_done);
                    errors++;
                end
                else
                begin
                    e = pending_verdicts.pop_front();
                    if (result_ch.is_inlier !== e.inl || result_ch.zero_denominator !== e.zden
                        || result_ch.inlier_total !== e.total || result_ch.set_done !== e.done)
                    begin
                        $display("%0t: mismatch expected inl=%b zden=%b total=%0d done=%b",
                                 $realtime, e.inl, e.zden, e.total, e.done);
                        $display("%0t:            actual inl=%b zden=%b total=%0d done=%b",
                                 $realtime, result_ch.is_inlier, result_ch.zero_denominator,
                                 result_ch.inlier_total, result_ch.set_done);
                        errors++;
                    end
                    n_inliers += e.inl;
                    n_zden += e.zden;
                    n_sets += e.done;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        pair_t p;
        verdict_t v;
        bit zero_loaded;
        errors = 0;
        n_pairs = 0;
        n_inliers = 0;
        n_zden = 0;
        n_sets = 0;
        n_results = 0;
        burst_left = 0;
        long_hold = 1'b0;
        zero_loaded = 1'b0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        pair_ch.valid <= 1'b0;
        pair_ch.src_x <= '0;
        pair_ch.src_y <= '0;
        pair_ch.dst_x <= '0;
        pair_ch.dst_y <= '0;
        pair_ch.last_pair <= 1'b0;
        coef_pairs[0] = 64'h0001_0000_0000_0000;
        coef_pairs[1] = '0;
        coef_pairs[2] = 64'h0001_0000_0000_0000;
        coef_pairs[3] = '0;
        coef_h22 = 32'h0001_0000;
        thr_sq = 32'd2304;
        tally = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed table, reset configuration first
        foreach (rows[i])
        begin
            if (rows[i].zero_cfg && !zero_loaded)
            begin
                drain();
                write_reg(CFG_COEF_PAIR_3, 64'd0);
                write_reg(CFG_COEF_H22, 64'd0);
                zero_loaded = 1'b1;
            end
            p = '{rows[i].sx, rows[i].sy, rows[i].tx, rows[i].ty, rows[i].last};
            v = '{rows[i].inl, rows[i].zden, rows[i].total, rows[i].last};
            send_pair(p, rows[i].known, v);
        end
        drain();

        // Threshold extremes on the identity
        write_all(64'h0001_0000_0000_0000, 64'd0, 64'h0001_0000_0000_0000, 64'd0,
                  32'h0001_0000, 32'd0);
        run_random(40, 10, 1'b0);
        drain();
        write_reg(CFG_THRESHOLD, 64'hFFFF_FFFF);
        run_random(40, 10, 1'b1);
        drain();

        // Divisor vanishes on the line x = 0
        write_all(64'h0001_0000_0000_0000, 64'd0, 64'h0001_0000_0000_0000,
                  64'h0001_0000_0000_0000, 32'd0, 32'd2304);
        for (int i = 0; i < 30; i++)
        begin
            make_pair(8, 1'b0, p);
            if ($urandom_range(0, 1) == 0)
                p.sx = '0;
            send_pair(p, 1'b0, v);
        end
        drain();

        // Coefficient extremes
        write_all(64'h7FFF_FFFF_7FFF_FFFF, 64'h7FFF_FFFF_8000_0000, 64'h8000_0000_7FFF_FFFF,
                  64'h8000_0000_8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        run_random(40, 12, 1'b1);
        drain();
        write_all(64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000, 64'h8000_0000_8000_0000,
                  64'h0000_0000_0000_0001, 32'h8000_0000, 32'd1);
        run_random(40, 12, 1'b1);
        drain();

        // Fully random words
        for (int k = 0; k < 3; k++)
        begin
            write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, $urandom, $urandom);
            run_random(30, 10, 1'b1);
            drain();
        end

        // Near-identity homographies with small perspective terms
        for (int k = 0; k < 12; k++)
        begin
            write_all({near(65536, 6000), near(0, 3000)},
                      {near(0, 1 << 22), near(0, 3000)},
                      {near(65536, 6000), near(0, 1 << 22)},
                      {near(0, 40), near(0, 40)},
                      near(65536, 4000), $urandom_range(0, 40000));
            if (k == 3)
            begin
                // hold the receiver while pairs keep coming
                long_hold = 1'b1;
                run_random(50, 20, 1'b0);
            end
            else if (k == 7)
            begin
                run_random(40, 20, 1'b0);
                pair_ch.valid <= 1'b0;
                burst_left = 0;
                while (pending_verdicts.size() != 0)
                    @(posedge clk);
                run_random(40, 20, 1'b0);
            end
            else
                run_random(100, 25, 1'b0);
            drain();
        end

        $display("covered %0d pairs in %0d sets over several homographies and thresholds",
                 n_pairs, n_sets);
        $display("results %0d, inliers %0d, zero divisors %0d, errors %0d",
                 n_results, n_inliers, n_zden, errors);
        if (errors == 0)
            $display("** homography_inlier_counter: PASSED **");
        else
            $display("** homography_inlier_counter: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
